/* sv/eprm_pkg.sv */
// Shared constants, register indexes and types for the echo pulse range meter.
`default_nettype none

package eprm_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 10;
    localparam int Q_SHIFT    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    localparam logic [DIST_W-1:0]  DIST_MAX       = 10'd1023;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd24391;
    localparam logic [DIST_W-1:0]  RANGE_LOW_RST  = 10'd30;
    localparam logic [DIST_W-1:0]  RANGE_HIGH_RST = 10'd700;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

    typedef struct packed {
        logic valid;
        logic fire;
        logic button;
    } eprm_ctl_t;

endpackage

`default_nettype wire

/* sv/eprm_front.sv */
// Input register, tick counter, echo edge capture and width-times-scale product stage.
`default_nettype none

module eprm_front #(
    parameter int COUNTER_BITS = eprm_pkg::COUNTER_BITS_DEF,
    localparam int PROD_W = COUNTER_BITS + eprm_pkg::SCALE_W
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    input  wire logic                         in_echo,
    input  wire logic                         in_button,
    output logic                              in_ready,
    input  wire logic [eprm_pkg::SCALE_W-1:0] scale,
    input  wire logic                         out_free,
    output eprm_pkg::eprm_ctl_t               ctl,
    output logic [PROD_W-1:0]                 prod
);
    import eprm_pkg::*;

    logic                    a_valid_reg, a_valid_next;
    logic                    a_echo_reg, a_button_reg;
    logic [COUNTER_BITS-1:0] tick_count_reg, tick_count_next;
    logic [COUNTER_BITS-1:0] rise_stamp_reg, rise_stamp_next;
    logic [COUNTER_BITS-1:0] width;
    logic                    waiting_fall_reg, waiting_fall_next;
    logic                    last_echo_reg, last_echo_next;
    eprm_ctl_t               ctl_reg, ctl_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    a_move, b_move, rise, fall;

    assign b_move   = ctl_reg.valid && (!ctl_reg.fire || out_free);
    assign a_move   = a_valid_reg && (!ctl_reg.valid || b_move);
    assign in_ready = !a_valid_reg || a_move;

    assign rise  = a_echo_reg && !last_echo_reg;
    assign fall  = !a_echo_reg && last_echo_reg && waiting_fall_reg;
    assign width = tick_count_reg - rise_stamp_reg;

    always_comb begin
        a_valid_next      = in_ready ? in_valid : a_valid_reg;
        tick_count_next   = tick_count_reg;
        rise_stamp_next   = rise_stamp_reg;
        waiting_fall_next = waiting_fall_reg;
        last_echo_next    = last_echo_reg;
        ctl_next          = ctl_reg;
        prod_next         = prod_reg;
        if (a_move) begin
            tick_count_next = tick_count_reg + 1'b1;
            last_echo_next  = a_echo_reg;
            if (rise) begin
                rise_stamp_next   = tick_count_reg;
                waiting_fall_next = 1'b1;
            end else if (fall) begin
                waiting_fall_next = 1'b0;
            end
            ctl_next.valid  = 1'b1;
            ctl_next.fire   = fall;
            ctl_next.button = a_button_reg;
            prod_next       = PROD_W'(width) * PROD_W'(scale);
        end else if (b_move) begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg      <= 1'b0;
            tick_count_reg   <= '0;
            rise_stamp_reg   <= '0;
            waiting_fall_reg <= 1'b0;
            last_echo_reg    <= 1'b0;
            ctl_reg          <= '0;
        end else begin
            a_valid_reg      <= a_valid_next;
            tick_count_reg   <= tick_count_next;
            rise_stamp_reg   <= rise_stamp_next;
            waiting_fall_reg <= waiting_fall_next;
            last_echo_reg    <= last_echo_next;
            ctl_reg          <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_echo_reg   <= in_echo;
            a_button_reg <= in_button;
        end
        prod_reg <= prod_next;
    end

    assign ctl  = ctl_reg;
    assign prod = prod_reg;

    // one count per tick taken into the product stage
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && a_move) |=> tick_count_reg == COUNTER_BITS'($past(tick_count_reg) + 1'b1))
        else $error("tick counter did not advance by one");

    a_fall_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && a_move && fall) |=> (ctl_reg.fire && !waiting_fall_reg))
        else $error("falling edge did not fire and clear capture");

endmodule

`default_nettype wire

/* sv/eprm_back.sv */
// Rounding and saturation to tenths, range check, min/max holds and result register.
`default_nettype none

module eprm_back #(
    parameter int COUNTER_BITS = eprm_pkg::COUNTER_BITS_DEF,
    localparam int PROD_W = COUNTER_BITS + eprm_pkg::SCALE_W
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire eprm_pkg::eprm_ctl_t            ctl,
    input  wire logic [PROD_W-1:0]              prod,
    input  wire logic [eprm_pkg::DIST_W-1:0]    range_low,
    input  wire logic [eprm_pkg::DIST_W-1:0]    range_high,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [eprm_pkg::M_TDATA_W-1:0]      m_tdata
);
    import eprm_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int QW    = SUM_W - Q_SHIFT;
    localparam int QX_W  = QW + DIST_W;

    logic [SUM_W-1:0]     sum;
    logic [QW-1:0]        q;
    logic [QX_W-1:0]      q_ext;
    logic [DIST_W-1:0]    tenths;
    logic                 in_range, ld, hold_en;
    logic [DIST_W-1:0]    mx0, mn0, mx1, mn1, mx_out, mn_out;
    logic [DIST_W-1:0]    max_hold_reg, max_hold_next, min_hold_reg, min_hold_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // round half up, then saturate
    assign sum      = SUM_W'(prod) + (SUM_W'(1) << (Q_SHIFT - 1));
    assign q        = sum[SUM_W-1:Q_SHIFT];
    assign q_ext    = QX_W'(q);
    assign tenths   = (q_ext > QX_W'(DIST_MAX)) ? DIST_MAX : q_ext[DIST_W-1:0];
    assign in_range = (tenths >= range_low) && (tenths <= range_high);

    assign out_free = !m_valid_reg || m_tready;
    assign ld       = ctl.valid && ctl.fire && out_free;
    assign hold_en  = ld && ctl.button;

    // empty holds take the first distance, in range or not
    assign mx0 = (max_hold_reg == '0 && min_hold_reg == '0) ? tenths : max_hold_reg;
    assign mn0 = (max_hold_reg == '0 && min_hold_reg == '0) ? tenths : min_hold_reg;
    assign mx1 = (in_range && tenths > mx0) ? tenths : mx0;
    assign mn1 = (in_range && tenths < mn0) ? tenths : mn0;
    assign mx_out = ctl.button ? mx1 : max_hold_reg;
    assign mn_out = ctl.button ? mn1 : min_hold_reg;

    always_comb begin
        max_hold_next = hold_en ? mx1 : max_hold_reg;
        min_hold_next = hold_en ? mn1 : min_hold_reg;
        m_valid_next  = out_free ? ld : m_valid_reg;
        m_data_next   = ld ? M_TDATA_W'({mn_out, mx_out, !in_range, tenths}) : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hold_reg <= '0;
            min_hold_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            max_hold_reg <= max_hold_next;
            min_hold_reg <= min_hold_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_hold_order: assert property (@(posedge aclk) disable iff (!aresetn)
        min_hold_reg <= max_hold_reg)
        else $error("min hold above max hold");

    a_hold_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !hold_en) |=> ($stable(max_hold_reg) && $stable(min_hold_reg)))
        else $error("holds moved without a held-button measurement");

endmodule

`default_nettype wire

/* sv/echo_pulse_range_meter_unit.sv */
// Top level of the echo pulse range meter: configuration registers and stage wiring.
//
// Each s_ transfer is one timer tick carrying the echo and button levels; a new tick is
// taken every cycle while results flow. The tick passes an input register, a stage that
// runs the free-running counter, detects echo edges and forms width times scale in one
// multiplier, and a stage that rounds, saturates, range-checks and updates the min/max
// holds into the result register. A falling echo edge that closes a captured pulse gives
// one m_ transfer once its tick has passed the stages into the result register; other
// ticks give none. The counter advances per accepted tick, not per clock. Configuration
// takes effect on the next tick and should be written only while no tick is in flight.
`default_nettype none

module echo_pulse_range_meter_unit #(
    parameter int COUNTER_BITS = eprm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] echo_level, [1] button_pressed
    input  wire logic [eprm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [9:0] distance_tenths, [10] out_of_range, [20:11] max_tenths, [30:21] min_tenths
    output logic [eprm_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [eprm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [eprm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import eprm_pkg::*;

    localparam int PROD_W = COUNTER_BITS + SCALE_W;

    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [DIST_W-1:0]  range_low_reg, range_low_next;
    logic [DIST_W-1:0]  range_high_reg, range_high_next;
    eprm_ctl_t          ctl;
    logic [PROD_W-1:0]  prod;
    logic               out_free;

    always_comb begin
        scale_next      = scale_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCALE:      scale_next      = cfg_wdata[SCALE_W-1:0];
                REG_RANGE_LOW:  range_low_next  = cfg_wdata[DIST_W-1:0];
                REG_RANGE_HIGH: range_high_next = cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= SCALE_RST;
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
        end else begin
            scale_reg      <= scale_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
        end
    end

    eprm_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_echo  (s_tdata[0]),
        .in_button(s_tdata[1]),
        .in_ready (s_tready),
        .scale    (scale_reg),
        .out_free (out_free),
        .ctl      (ctl),
        .prod     (prod)
    );

    eprm_back #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .prod      (prod),
        .range_low (range_low_reg),
        .range_high(range_high_reg),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* dv/eprm_tb_pkg.sv */
`timescale 1ns / 100ps
// Tick-by-tick prediction of echo distance readings and their comparison with the unit.
package eprm_tb_pkg;

    import eprm_pkg::*;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              out_of_range;
        logic [DIST_W-1:0] max_tenths;
        logic [DIST_W-1:0] min_tenths;
    } reading_t;

    class pulse_distance_tracker;
        logic [SCALE_W-1:0]          scale;
        logic [DIST_W-1:0]           range_lo;
        logic [DIST_W-1:0]           range_hi;
        logic [COUNTER_BITS_DEF-1:0] tick_count;
        logic [COUNTER_BITS_DEF-1:0] rise_stamp;
        bit                          waiting_fall;
        bit                          last_echo;
        logic [DIST_W-1:0]           max_hold;
        logic [DIST_W-1:0]           min_hold;
        reading_t                    expected_q[$];
        int unsigned                 predicted;
        int unsigned                 checked;
        int unsigned                 mismatches;

        function new();
            scale        = SCALE_RST;
            range_lo     = RANGE_LOW_RST;
            range_hi     = RANGE_HIGH_RST;
            tick_count   = '0;
            rise_stamp   = '0;
            waiting_fall = 1'b0;
            last_echo    = 1'b0;
            max_hold     = '0;
            min_hold     = '0;
            predicted    = 0;
            checked      = 0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SCALE:      scale = value[SCALE_W-1:0];
                REG_RANGE_LOW:  range_lo = value[DIST_W-1:0];
                REG_RANGE_HIGH: range_hi = value[DIST_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted tick; a falling edge closing a captured pulse queues a reading
        function void take_tick(bit echo, bit button);
            logic [COUNTER_BITS_DEF-1:0]    width;
            logic [SCALE_W+COUNTER_BITS_DEF:0] product;
            logic [DIST_W-1:0]              tenths;
            bit                             in_range;
            reading_t                       r;
            if (echo && !last_echo) begin
                rise_stamp   = tick_count;
                waiting_fall = 1'b1;
            end else if (!echo && last_echo && waiting_fall) begin
                width   = tick_count - rise_stamp;
                product = 33'(width) * 33'(scale) + (33'd1 << (Q_SHIFT - 1));
                tenths  = ((product >> Q_SHIFT) > 33'(DIST_MAX)) ? DIST_MAX
                                                               : product[Q_SHIFT +: DIST_W];
                in_range     = (tenths >= range_lo) && (tenths <= range_hi);
                waiting_fall = 1'b0;
                if (button) begin
                    if (max_hold == '0 && min_hold == '0) begin
                        max_hold = tenths;
                        min_hold = tenths;
                    end
                    if (in_range && tenths > max_hold) max_hold = tenths;
                    if (in_range && tenths < min_hold) min_hold = tenths;
                end
                r.distance     = tenths;
                r.out_of_range = !in_range;
                r.max_tenths   = max_hold;
                r.min_tenths   = min_hold;
                expected_q.push_back(r);
                predicted++;
            end
            last_echo  = echo;
            tick_count = tick_count + 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reading(logic [M_TDATA_W-1:0] data);
            reading_t e;
            checked++;
            if (expected_q.size() == 0) begin
                $error("reading with none expected: m_tdata %h", data);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("distance_tenths", 32'(e.distance), 32'(data[9:0]));
            compare_field("out_of_range", 32'(e.out_of_range), 32'(data[10]));
            compare_field("max_tenths", 32'(e.max_tenths), 32'(data[20:11]));
            compare_field("min_tenths", 32'(e.min_tenths), 32'(data[30:21]));
            compare_field("pad", 32'd0, 32'(data[M_TDATA_W-1:31]));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives timer ticks and register writes into the range meter and checks readings.
module tb;

    import eprm_pkg::*;
    import eprm_tb_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 600;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pulse_distance_tracker tracker;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned idle_cycles    = 0;
    int unsigned ticks_sent     = 0;
    int unsigned phases         = 0;

    echo_pulse_range_meter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check each transfer, then pick next tready
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) tracker.check_reading(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_tick(input bit echo, input bit button);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({button, echo});
        do @(posedge aclk); while (!s_tready);
        tracker.take_tick(echo, button);
        ticks_sent++;
    endtask

    // low lead-in, high for width ticks, then the falling tick with the given button
    task automatic send_pulse(input int lead, input int width, input bit btn_fall);
        bit btn;
        btn = 1'($urandom_range(1));
        repeat (lead) send_tick(1'b0, 1'($urandom_range(1)));
        repeat (width) send_tick(1'b1, btn);
        send_tick(1'b0, btn_fall);
    endtask

    task automatic wait_readings();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic drain();
        wait_readings();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [SCALE_W-1:0] scale, input logic [DIST_W-1:0] lo,
                            input logic [DIST_W-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SCALE;
        cfg_wdata <= CFG_DATA_W'(scale);
        @(posedge aclk);
        tracker.write_reg(REG_SCALE, CFG_DATA_W'(scale));
        cfg_index <= REG_RANGE_LOW;
        cfg_wdata <= CFG_DATA_W'(lo);
        @(posedge aclk);
        tracker.write_reg(REG_RANGE_LOW, CFG_DATA_W'(lo));
        cfg_index <= REG_RANGE_HIGH;
        cfg_wdata <= CFG_DATA_W'(hi);
        @(posedge aclk);
        tracker.write_reg(REG_RANGE_HIGH, CFG_DATA_W'(hi));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    initial begin
        int unsigned      tick_base;
        int unsigned      roll;
        logic [SCALE_W-1:0] scale;
        logic [DIST_W-1:0]  lo;
        logic [DIST_W-1:0]  hi;

        tracker   = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SCALE;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, first reading latches both holds
        send_pulse(1, 1, 1'b1);
        send_pulse(1, 3, 1'b0);
        drain();
        set_regs(16'hFFFF, '0, DIST_MAX);
        send_pulse(1, 2, 1'b1);
        send_pulse(1, 70, 1'b1);
        send_pulse(1, 33, 1'b1);
        send_pulse(1, 40, 1'b0);
        drain();
        set_regs(16'hFFFF, DIST_MAX, '0);      // inverted range
        send_pulse(1, 64, 1'b1);
        drain();
        set_regs('0, '0, '0);
        send_pulse(1, 5, 1'b1);

        tick_base = ticks_sent;
        while (ticks_sent - tick_base < 1000 || phases < 4) begin
            drain();
            set_mode(phases % 4);
            case ($urandom_range(3))
                0: scale = 16'hFFFF;
                1: scale = SCALE_W'($urandom_range(65535));
                2: scale = SCALE_W'($urandom_range(65535, 40000));
                default: scale = SCALE_RST;
            endcase
            lo = DIST_W'($urandom_range(8));
            hi = ($urandom_range(7) == 0) ? DIST_MAX : DIST_W'($urandom_range(30, 2));
            if ($urandom_range(7) == 0) lo = hi + 1'b1;
            set_regs(scale, lo, hi);
            if (phases == 2) hold_left = LONG_HOLD;
            for (int k = 0; k < 8; k++) begin
                if (k == 4 && phases % 3 == 1) wait_readings();
                roll = $urandom_range(99);
                if (roll < 77)
                    send_pulse($urandom_range(6, 1), $urandom_range(60, 1),
                               1'($urandom_range(1)));
                else if (roll < 85)
                    send_pulse($urandom_range(3, 1), $urandom_range(200, 61),
                               1'($urandom_range(1)));
                else
                    repeat ($urandom_range(12, 1))
                        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            phases++;
        end
        drain();

        $display("covered %0d ticks, %0d readings checked over %0d random phases",
                 ticks_sent, tracker.checked, phases);
        $display("scale and range extremes, inverted range, long receiver hold, stalls");
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
